/* rtl/assert_macros.svh */
// Assertion macros used by the knapsack solver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define KDP_ASSERT(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// Same, on the block clock clk and reset arst_n.
`define KDP_ASSERT_DFLT(label, prop, msg) \
	`KDP_ASSERT(label, clk, arst_n, prop, msg)

`endif

/* rtl/kdp_pkg.sv */
// Types and constants of the 0/1 knapsack solver.
package kdp_pkg;

	localparam int AMT_W   = 16;
	localparam int WT_W    = 10;
	localparam int VAL_W   = 12;
	localparam int IDX_W   = 5;
	localparam int CAPR_W  = 10;

	localparam logic [CAPR_W-1:0] CAP_RESET = 10'd13;

	localparam logic KIND_TOTAL = 1'b0;
	localparam logic KIND_ITEM  = 1'b1;

	// result of one row cell update
	typedef struct packed {
		logic             take;
		logic [AMT_W-1:0] best;
	} upd_t;

endpackage

/* rtl/kdp_alu.sv */
// Saturating add and compare unit shared by every row cell update.
module kdp_alu import kdp_pkg::*; (
	input  logic [AMT_W-1:0] old_best,
	input  logic [AMT_W-1:0] base_best,
	input  logic [VAL_W-1:0] item_value,
	input  logic             fits,
	output upd_t             upd
);

	logic [AMT_W:0]   sum;
	logic [AMT_W-1:0] sat;

	assign sum      = {1'b0, base_best} + (AMT_W+1)'(item_value);
	assign sat      = sum[AMT_W] ? {AMT_W{1'b1}} : sum[AMT_W-1:0];
	assign upd.take = fits && (sat > old_best);
	assign upd.best = sat;

endmodule

/* rtl/kdp_row_mem.sv */
// Best-value row memory: one write port, two registered read ports.
module kdp_row_mem import kdp_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [AMT_W-1:0] wr_data,
	input  logic [AW-1:0]    rd_a_addr,
	input  logic [AW-1:0]    rd_b_addr,
	output logic [AMT_W-1:0] rd_a_data,
	output logic [AMT_W-1:0] rd_b_data
);

	logic [AMT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_data <= mem[rd_a_addr];
		rd_b_data <= mem[rd_b_addr];
	end

endmodule

/* rtl/kdp_take_mem.sv */
// Take-bit memory, one bit per (item, capacity) pair, registered read.
module kdp_take_mem #(
	parameter int AW = 14
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic          wr_bit,
	input  logic [AW-1:0] rd_addr,
	output logic          rd_bit
);

	logic mem [2**AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_bit;
		end
		rd_bit <= mem[rd_addr];
	end

endmodule

/* rtl/knapsack_01_dp_solver.sv */
// Top level of the 0/1 knapsack dynamic programming solver.
// Input channel: item_weight, item_value, last_item with in_valid / in_stall.
// A word is taken when in_valid is high and in_stall is low; in_stall is high
// whenever the sequencer is busy. Each stored item sweeps the best-value row
// from cap down to 0, one cell per cycle through a shared add/compare unit
// (cap = min(capacity, MAX_CAPACITY)). Items past MAX_ITEMS are dropped and
// flagged. After a word with last_item, traceback walks the stored items,
// then 1 + chosen result words leave on the output channel (out_valid /
// out_stall), the total first and the final one with last_result set.
// A stalled receiver holds the output register and the sequencer with it.
// Once the final word is loaded the row is cleared, one entry per cycle,
// before the next item is taken.
// Reset starts the same clearing pass and sets capacity to 13.
// cfg_we / cfg_wdata write capacity; write it only while idle.
module knapsack_01_dp_solver import kdp_pkg::*; #(
	parameter int MAX_ITEMS    = 16,
	parameter int MAX_CAPACITY = 1023
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CAPR_W-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [WT_W-1:0]   item_weight,
	input  logic [VAL_W-1:0]  item_value,
	input  logic              last_item,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              record_kind,
	output logic [AMT_W-1:0]  amount,
	output logic [IDX_W-1:0]  chosen_index,
	output logic [WT_W-1:0]   chosen_weight,
	output logic              too_many_items,
	output logic              last_result
);

`include "assert_macros.svh"

	localparam int CAP_MAX = (MAX_CAPACITY < 1023) ? MAX_CAPACITY : 1023;
	localparam int ROW_D   = CAP_MAX + 1;
	localparam int ROW_AW  = (ROW_D > 1) ? $clog2(ROW_D) : 1;
	localparam int K_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
	localparam int TAW     = K_W + ROW_AW;

	localparam logic [CAPR_W-1:0] CAP_MAX_V = CAPR_W'(CAP_MAX);
	localparam logic [ROW_AW-1:0] CLR_LAST  = ROW_AW'(ROW_D - 1);
	localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_ITEMS);

	localparam logic [2:0] ST_CLEAR    = 3'd0;
	localparam logic [2:0] ST_IDLE     = 3'd1;
	localparam logic [2:0] ST_UPD      = 3'd2;
	localparam logic [2:0] ST_TB_START = 3'd3;
	localparam logic [2:0] ST_TB_READ  = 3'd4;
	localparam logic [2:0] ST_TB_EVAL  = 3'd5;
	localparam logic [2:0] ST_EMIT     = 3'd6;

	logic [2:0]        state_q;
	logic [ROW_AW-1:0] clr_addr_q;
	logic [CAPR_W-1:0] capacity_q;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic              last_pend_q;
	logic [ROW_AW-1:0] solve_cap_q;

	logic [WT_W-1:0]   cur_w_q;
	logic [VAL_W-1:0]  cur_v_q;
	logic [K_W-1:0]    cur_k_q;
	logic [ROW_AW-1:0] upd_c_q;
	logic              issue_q;
	logic              vld_s1;
	logic              fits_s1;
	logic [ROW_AW-1:0] c_s1;

	logic [WT_W-1:0]   weight_store [MAX_ITEMS];
	logic [VAL_W-1:0]  value_store  [MAX_ITEMS];
	logic [ROW_AW-1:0] capw_store   [MAX_ITEMS];
	logic [K_W-1:0]    chosen_q     [MAX_ITEMS];

	logic [ROW_AW-1:0] tb_c_q;
	logic [K_W-1:0]    tb_k_q;
	logic [CNT_W-1:0]  tb_left_q;
	logic [CNT_W-1:0]  n_chosen_q;
	logic [AMT_W-1:0]  total_q;
	logic [CNT_W-1:0]  emit_i_q;

	logic              out_valid_q;
	logic              record_kind_q;
	logic [AMT_W-1:0]  amount_q;
	logic [IDX_W-1:0]  chosen_index_q;
	logic [WT_W-1:0]   chosen_weight_q;
	logic              too_many_q;
	logic              last_result_q;

	logic [CAPR_W-1:0] cap10;
	logic [ROW_AW-1:0] cap_eff;
	logic              in_acc;
	logic              has_room;
	logic [K_W-1:0]    wr_k;

	logic              row_we;
	logic [ROW_AW-1:0] row_wa;
	logic [AMT_W-1:0]  row_wd;
	logic [ROW_AW-1:0] row_ra;
	logic [ROW_AW-1:0] row_rb;
	logic [AMT_W-1:0]  row_da;
	logic [AMT_W-1:0]  row_db;
	upd_t              upd;
	logic              take_rd;

	logic              tb_take;
	logic              load;
	logic              rec_last;
	logic [CNT_W-1:0]  emit_prev;
	logic [K_W-1:0]    sel;
	logic [K_W:0]      sel_p1;
	logic              last_acc;

	assign cap10    = (capacity_q > CAP_MAX_V) ? CAP_MAX_V : capacity_q;
	assign cap_eff  = cap10[ROW_AW-1:0];
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign has_room = (count_q < CNT_MAX);
	assign wr_k     = count_q[K_W-1:0];

	// row memory port muxing: clearing pass or cell write-back
	always_comb begin
		if (state_q == ST_CLEAR) begin
			row_we = 1'b1;
			row_wa = clr_addr_q;
			row_wd = '0;
		end else begin
			row_we = vld_s1 && upd.take;
			row_wa = c_s1;
			row_wd = upd.best;
		end
	end

	assign row_ra = (state_q == ST_UPD) ? upd_c_q : solve_cap_q;
	assign row_rb = upd_c_q - cur_w_q[ROW_AW-1:0];

	kdp_row_mem #(
		.DEPTH (ROW_D),
		.AW    (ROW_AW)
	) u_row (
		.clk       (clk),
		.wr_en     (row_we),
		.wr_addr   (row_wa),
		.wr_data   (row_wd),
		.rd_a_addr (row_ra),
		.rd_b_addr (row_rb),
		.rd_a_data (row_da),
		.rd_b_data (row_db)
	);

	kdp_alu u_alu (
		.old_best   (row_da),
		.base_best  (row_db),
		.item_value (cur_v_q),
		.fits       (fits_s1),
		.upd        (upd)
	);

	kdp_take_mem #(
		.AW (TAW)
	) u_take (
		.clk     (clk),
		.wr_en   (vld_s1),
		.wr_addr ({cur_k_q, c_s1}),
		.wr_bit  (upd.take),
		.rd_addr ({tb_k_q, tb_c_q}),
		.rd_bit  (take_rd)
	);

	// an item only owns take bits up to the cap it was swept with
	assign tb_take   = take_rd && (tb_c_q <= capw_store[tb_k_q]);

	assign load      = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign rec_last  = (emit_i_q == n_chosen_q);
	assign emit_prev = emit_i_q - CNT_W'(1);
	assign sel       = chosen_q[emit_prev[K_W-1:0]];
	assign sel_p1    = (K_W+1)'(sel) + (K_W+1)'(1);
	assign last_acc  = out_valid_q && !out_stall && last_result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			capacity_q  <= CAP_RESET;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			last_pend_q <= 1'b0;
			solve_cap_q <= '0;
			upd_c_q     <= '0;
			issue_q     <= 1'b0;
			vld_s1      <= 1'b0;
			tb_c_q      <= '0;
			tb_k_q      <= '0;
			tb_left_q   <= '0;
			n_chosen_q  <= '0;
			emit_i_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			vld_s1 <= (state_q == ST_UPD) && issue_q;
			if (out_valid_q && !out_stall && !load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ROW_AW'(1);
					if (clr_addr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						solve_cap_q <= cap_eff;
						last_pend_q <= last_item;
						if (has_room) begin
							upd_c_q <= cap_eff;
							issue_q <= 1'b1;
							state_q <= ST_UPD;
						end else begin
							ovf_q <= 1'b1;
							if (last_item) begin
								state_q <= ST_TB_START;
							end
						end
					end
				end
				ST_UPD: begin
					if (issue_q) begin
						if (upd_c_q == '0) begin
							issue_q <= 1'b0;
						end else begin
							upd_c_q <= upd_c_q - ROW_AW'(1);
						end
					end else if (vld_s1) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= last_pend_q ? ST_TB_START : ST_IDLE;
					end
				end
				ST_TB_START: begin
					tb_c_q     <= solve_cap_q;
					tb_k_q     <= K_W'(count_q - CNT_W'(1));
					tb_left_q  <= count_q;
					n_chosen_q <= '0;
					emit_i_q   <= '0;
					state_q    <= ST_TB_READ;
				end
				ST_TB_READ: begin
					state_q <= (tb_left_q == '0) ? ST_EMIT : ST_TB_EVAL;
				end
				ST_TB_EVAL: begin
					if (tb_take) begin
						n_chosen_q <= n_chosen_q + CNT_W'(1);
						tb_c_q     <= tb_c_q - weight_store[tb_k_q][ROW_AW-1:0];
					end
					tb_k_q    <= tb_k_q - K_W'(1);
					tb_left_q <= tb_left_q - CNT_W'(1);
					state_q   <= ST_TB_READ;
				end
				ST_EMIT: begin
					if (load) begin
						out_valid_q <= 1'b1;
						emit_i_q    <= emit_i_q + CNT_W'(1);
						if (rec_last) begin
							count_q    <= '0;
							ovf_q      <= 1'b0;
							n_chosen_q <= '0;
							clr_addr_q <= '0;
							state_q    <= ST_CLEAR;
						end
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// item stores, sweep pipeline payload, traceback captures and output word
	always_ff @(posedge clk) begin
		if (in_acc && has_room) begin
			weight_store[wr_k] <= item_weight;
			value_store[wr_k]  <= item_value;
			capw_store[wr_k]   <= cap_eff;
			cur_w_q            <= item_weight;
			cur_v_q            <= item_value;
			cur_k_q            <= wr_k;
		end
		c_s1    <= upd_c_q;
		fits_s1 <= (cur_w_q <= CAPR_W'(upd_c_q));
		if (state_q == ST_TB_READ) begin
			total_q <= row_da;
		end
		if (state_q == ST_TB_EVAL && tb_take) begin
			chosen_q[n_chosen_q[K_W-1:0]] <= tb_k_q;
		end
		if (load) begin
			too_many_q    <= ovf_q;
			last_result_q <= rec_last;
			if (emit_i_q == '0) begin
				record_kind_q   <= KIND_TOTAL;
				amount_q        <= total_q;
				chosen_index_q  <= '0;
				chosen_weight_q <= '0;
			end else begin
				record_kind_q   <= KIND_ITEM;
				amount_q        <= AMT_W'(value_store[sel]);
				chosen_index_q  <= IDX_W'(sel_p1);
				chosen_weight_q <= weight_store[sel];
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign record_kind    = record_kind_q;
	assign amount         = amount_q;
	assign chosen_index   = chosen_index_q;
	assign chosen_weight  = chosen_weight_q;
	assign too_many_items = too_many_q;
	assign last_result    = last_result_q;

	`KDP_ASSERT_DFLT(a_count_bound, count_q <= CNT_MAX, "item count past limit")
	`KDP_ASSERT_DFLT(a_chosen_bound, n_chosen_q <= count_q, "more chosen than stored items")
	`KDP_ASSERT_DFLT(a_store_busy, in_acc && has_room |=> in_stall, "stored item did not start sweep")
	`KDP_ASSERT(a_last_closes, clk, arst_n, last_acc |=> !out_valid_q, "word after final result")

endmodule

/* dv/knapsack_01_dp_solver_test.sv */
// Self-checking testbench for the 0/1 knapsack solver with a DP predictor.
module knapsack_01_dp_solver_test import kdp_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_ITEMS   = 16;
	localparam int MAX_CAP     = 1023;
	localparam int SETTLE      = 1100;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [WT_W-1:0]  weight;
		logic [VAL_W-1:0] value;
		logic             ends_set;
	} item_word_t;

	typedef struct packed {
		logic             kind;
		logic [AMT_W-1:0] amount;
		logic [IDX_W-1:0] index;
		logic [WT_W-1:0]  weight;
		logic             dropped;
		logic             ends;
	} solution_rec_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CAPR_W-1:0] cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [WT_W-1:0]   item_weight = '0;
	logic [VAL_W-1:0]  item_value = '0;
	logic              last_item = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              record_kind;
	logic [AMT_W-1:0]  amount;
	logic [IDX_W-1:0]  chosen_index;
	logic [WT_W-1:0]   chosen_weight;
	logic              too_many_items;
	logic              last_result;

	item_word_t    item_queue[$];
	solution_rec_t solution_queue[$];
	int            fail_count = 0;
	int            cycle_count = 0;
	logic          calm = 1'b0;

	// predictor state
	logic [AMT_W-1:0]  row_best [0:MAX_CAP];
	logic [15:0]       row_take [0:MAX_CAP];
	logic [WT_W-1:0]   wt_store [0:MAX_ITEMS-1];
	logic [VAL_W-1:0]  val_store [0:MAX_ITEMS-1];
	int                items_held;
	logic              overflowed;
	logic [CAPR_W-1:0] cap_now;

	knapsack_01_dp_solver #(
		.MAX_ITEMS(MAX_ITEMS),
		.MAX_CAPACITY(MAX_CAP)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.item_weight(item_weight),
		.item_value(item_value),
		.last_item(last_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.record_kind(record_kind),
		.amount(amount),
		.chosen_index(chosen_index),
		.chosen_weight(chosen_weight),
		.too_many_items(too_many_items),
		.last_result(last_result)
	);

	always #4 clk = ~clk;

	task automatic clear_dp_set();
		for (int c = 0; c <= MAX_CAP; c++) begin
			row_best[c] = '0;
			row_take[c] = '0;
		end
		for (int k = 0; k < MAX_ITEMS; k++) begin
			wt_store[k] = '0;
			val_store[k] = '0;
		end
		items_held = 0;
		overflowed = 1'b0;
	endtask

	task automatic fold_item(input logic [WT_W-1:0] wt, input logic [VAL_W-1:0] val,
			input logic closes);
		int unsigned   cand;
		int            c;
		int            k;
		int            picks[$];
		solution_rec_t rec;
		if (items_held < MAX_ITEMS) begin
			k = items_held;
			wt_store[k] = wt;
			val_store[k] = val;
			for (c = int'(cap_now); c >= 0; c--) begin
				row_take[c][k] = 1'b0;
				if (int'(wt) <= c) begin
					cand = 32'(row_best[c - int'(wt)]) + 32'(val);
					if (cand > 32'hFFFF)
						cand = 32'hFFFF;
					if (cand > 32'(row_best[c])) begin
						row_best[c] = cand[AMT_W-1:0];
						row_take[c][k] = 1'b1;
					end
				end
			end
			items_held++;
		end else begin
			overflowed = 1'b1;
		end
		if (!closes)
			return;
		// traceback, highest index first
		c = int'(cap_now);
		for (k = items_held - 1; k >= 0; k--) begin
			if (row_take[c][k]) begin
				picks.push_back(k);
				c -= int'(wt_store[k]);
			end
		end
		rec = '{KIND_TOTAL, row_best[cap_now], '0, '0, overflowed, picks.size() == 0};
		solution_queue.push_back(rec);
		foreach (picks[i]) begin
			rec = '{KIND_ITEM, AMT_W'(val_store[picks[i]]), IDX_W'(picks[i] + 1),
				wt_store[picks[i]], overflowed, i == picks.size() - 1};
			solution_queue.push_back(rec);
		end
		clear_dp_set();
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endtask

	task automatic queue_word(input logic [WT_W-1:0] wt, input logic [VAL_W-1:0] val,
			input logic closes);
		item_word_t w;
		w = '{wt, val, closes};
		item_queue.push_back(w);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (item_queue.size() != 0 || in_valid || solution_queue.size() != 0);
	endtask

	task automatic program_capacity(input logic [CAPR_W-1:0] cap);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_now = cap;
		@(negedge clk);
	endtask

	// driver
	always @(posedge clk) begin
		item_word_t nxt;
		if (in_valid && !in_stall)
			fold_item(item_weight, item_value, last_item);
		if (!in_valid || !in_stall) begin
			if (item_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 21)) begin
				nxt = item_queue.pop_front();
				in_valid <= 1'b1;
				item_weight <= nxt.weight;
				item_value <= nxt.value;
				last_item <= nxt.ends_set;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		solution_rec_t want;
		if (out_valid && !out_stall) begin
			if (solution_queue.size() == 0) begin
				$error("unexpected result word: kind %0d amount %0d index %0d",
					record_kind, amount, chosen_index);
				fail_count++;
			end else begin
				want = solution_queue.pop_front();
				check_field("record_kind", 32'(want.kind), 32'(record_kind));
				check_field("amount", 32'(want.amount), 32'(amount));
				check_field("chosen_index", 32'(want.index), 32'(chosen_index));
				check_field("chosen_weight", 32'(want.weight), 32'(chosen_weight));
				check_field("too_many_items", 32'(want.dropped), 32'(too_many_items));
				check_field("last_result", 32'(want.ends), 32'(last_result));
			end
		end
		out_stall <= !calm && ($urandom_range(0, 99) < 21);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned       set_size;
		int unsigned       split_at;
		int unsigned       roll;
		int unsigned       counted;
		int unsigned       set_no;
		logic [CAPR_W-1:0] set_cap;
		logic [WT_W-1:0]   wt;
		logic [VAL_W-1:0]  val;
		cap_now = CAP_RESET;
		clear_dp_set();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// plain set at reset capacity
		queue_word(5, 10, 1'b0);
		queue_word(4, 40, 1'b0);
		queue_word(3, 50, 1'b1);
		// zero capacity: zero weight taken, any nonzero weight too heavy
		program_capacity(0);
		queue_word(0, 4095, 1'b0);
		queue_word(1, 7, 1'b1);
		// full capacity, heaviest item
		program_capacity(CAPR_W'(MAX_CAP));
		queue_word(1023, 4095, 1'b0);
		queue_word(512, 3000, 1'b1);
		// capacity lowered mid-set
		program_capacity(13);
		queue_word(6, 30, 1'b0);
		program_capacity(6);
		queue_word(13, 99, 1'b1);
		// nothing chosen
		program_capacity(5);
		queue_word(20, 100, 1'b1);
		// one word past the item limit, carrying last
		for (int i = 0; i <= MAX_ITEMS; i++)
			queue_word(WT_W'(i % 7), (i == 3) ? '0 : VAL_W'(100 + i * 37), i == MAX_ITEMS);

		counted = 0;
		set_no = 0;
		while (counted < 380) begin
			calm = (set_no >= 12 && set_no < 20);
			roll = $urandom_range(0, 99);
			if (roll < 4)
				set_cap = CAPR_W'($urandom_range(600, MAX_CAP));
			else if (roll < 10)
				set_cap = 0;
			else
				set_cap = CAPR_W'($urandom_range(1, 60));
			if ($urandom_range(0, 1) != 0 && set_cap != cap_now)
				program_capacity(set_cap);
			set_cap = cap_now;
			roll = $urandom_range(0, 99);
			if (set_cap > 100)
				set_size = $urandom_range(1, 3);
			else if (roll < 12)
				set_size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
			else
				set_size = $urandom_range(1, MAX_ITEMS);
			split_at = set_size;
			if (set_size >= 2 && set_cap > 0 && $urandom_range(0, 99) < 10)
				split_at = $urandom_range(1, set_size - 1);
			for (int i = 0; i < set_size; i++) begin
				if (i == split_at)
					program_capacity(CAPR_W'($urandom_range(0, cap_now - 1)));
				roll = $urandom_range(0, 99);
				if (roll < 65)
					wt = WT_W'($urandom_range(0, cap_now));
				else if (roll < 80)
					wt = WT_W'($urandom_range(0, cap_now / 4));
				else
					wt = WT_W'($urandom());
				roll = $urandom_range(0, 99);
				if (roll < 8)
					val = '0;
				else if (roll < 16)
					val = '1;
				else
					val = VAL_W'($urandom());
				queue_word(wt, val, i == set_size - 1);
			end
			counted += set_size;
			set_no++;
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* knapsack_01_dp_solver.f */
+incdir+rtl
rtl/kdp_pkg.sv
rtl/kdp_alu.sv
rtl/kdp_row_mem.sv
rtl/kdp_take_mem.sv
rtl/knapsack_01_dp_solver.sv
dv/knapsack_01_dp_solver_test.sv
